// File: hw/rtl/xalu_pkg.sv
// package for the x86 integer alu: operation codes, sizes, sequencer states
// no dependencies
`default_nettype none
package xalu_pkg;
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_CMP = 4'd2, OP_INC = 4'd3, OP_ADC = 4'd4,
    OP_SBB = 4'd5, OP_MUL = 4'd6, OP_IMUL1 = 4'd7, OP_IMUL2 = 4'd8,
    OP_IMUL3 = 4'd9, OP_DIV = 4'd10, OP_IDIV = 4'd11
  } op_e;
  typedef enum logic [1:0] {SZ_BYTE = 2'd0, SZ_WORD = 2'd1} size_e;
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_MULFIX, ST_DIV, ST_DIVFIX, ST_OUT
  } state_e;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW = 6;
endpackage
`default_nettype wire

// File: hw/rtl/x86_integer_alu_with_flags.sv
// x86 integer alu with cf/zf/sf/of flags, iterative multiply and divide
// depends on xalu_pkg
// add/sub/cmp/inc/adc/sbb go straight from idle to the output register,
// multiplies take one shift-add step per multiplier bit,
// divides one restoring quotient bit per cycle over a 2w-bit dividend, w = 8/16/32
// one item at a time; s_axis_tready is high only while the sequencer idles
// asynchronous active-low reset clears flags, sequencer and output valid
`default_nettype none
module x86_integer_alu_with_flags import xalu_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op_size[1:0], dest_value, src_value, src2_value, acc_low_in, acc_high_in
  input  wire logic [167:0] s_axis_tdata,
  // req_type[3:0]
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // dest_result, dest_write, acc_low_out, acc_high_out, acc_write,
  // flag_cf, flag_zf, flag_sf, flag_of, divide_error, zero fill
  output logic [103:0]      m_axis_tdata
);
  state_e st_q, st_d;
  logic [3:0] flags_q, flags_d;
  logic [3:0] op_q, op_d;
  logic [5:0] w_q, w_d;
  logic [31:0] m_q, m_d, sb_q, sb_d;
  logic [31:0] a_q, a_d, b_q, b_d;       // a: multiplicand/divisor, b: multiplier
  logic [63:0] acc_q, acc_d;             // product or dividend/quotient shifter
  logic [31:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic nn_q, nn_d, nd_q, nd_d;
  logic [31:0] dres_q, dres_d, lo_q, lo_d, hi_q, hi_d;
  logic dw_q, dw_d, aw_q, aw_d, err_q, err_d;

  logic [1:0] sz;
  logic [31:0] wm, wsb, d, s, s2, alo, ahi;
  logic [5:0] wn;
  logic [32:0] sum;
  logic [32:0] sub_v;
  logic [32:0] trial;
  logic [63:0] dvd, wm2, nsb2;
  logic c;

  assign sz  = s_axis_tdata[1:0];
  assign wn  = (sz == SZ_BYTE) ? 6'd8 : (sz == SZ_WORD) ? 6'd16 : 6'd32;
  assign wm  = (sz == SZ_BYTE) ? 32'hFF : (sz == SZ_WORD) ? 32'hFFFF : 32'hFFFF_FFFF;
  assign wsb = (sz == SZ_BYTE) ? 32'h80 : (sz == SZ_WORD) ? 32'h8000 : 32'h8000_0000;
  assign d   = s_axis_tdata[33:2] & wm;
  assign s   = s_axis_tdata[65:34] & wm;
  assign s2  = s_axis_tdata[97:66] & wm;
  assign alo = s_axis_tdata[129:98];
  assign ahi = s_axis_tdata[161:130];
  assign c   = flags_q[0];
  assign wm2 = (sz == SZ_BYTE) ? 64'hFFFF : (sz == SZ_WORD) ? 64'hFFFF_FFFF : '1;
  assign nsb2 = (sz == SZ_BYTE) ? 64'h8000 : (sz == SZ_WORD) ? 64'h8000_0000
              : 64'h8000_0000_0000_0000;
  assign dvd = (sz == SZ_BYTE) ? {48'd0, alo[15:0]}
             : (sz == SZ_WORD) ? {32'd0, ahi[15:0], alo[15:0]} : {ahi, alo};
  assign sum   = {1'b0, d} + {1'b0, s} + {32'd0, (s_axis_tuser == OP_ADC) & c};
  assign sub_v = {1'b0, s} + {32'd0, (s_axis_tuser == OP_SBB) & c};
  assign trial = {rem_q, acc_q[63]} - {1'b0, a_q};

  assign s_axis_tready = (st_q == ST_IDLE);

  always_comb begin
    logic [31:0] r;
    logic [63:0] p;
    logic [63:0] qx;
    logic [31:0] rx;
    r = '0; p = '0; qx = '0; rx = '0;
    st_d = st_q; flags_d = flags_q; op_d = op_q; w_d = w_q; m_d = m_q; sb_d = sb_q;
    a_d = a_q; b_d = b_q; acc_d = acc_q; rem_d = rem_q; cnt_d = cnt_q;
    nn_d = nn_q; nd_d = nd_q; dres_d = dres_q; lo_d = lo_q; hi_d = hi_q;
    dw_d = dw_q; aw_d = aw_q; err_d = err_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid) begin
        op_d = s_axis_tuser; w_d = wn; m_d = wm; sb_d = wsb;
        dres_d = '0; lo_d = '0; hi_d = '0; dw_d = 1'b0; aw_d = 1'b0; err_d = 1'b0;
        cnt_d = '0; acc_d = '0; rem_d = '0; nn_d = 1'b0; nd_d = 1'b0;
        st_d = ST_OUT;
        priority case (s_axis_tuser)
          OP_ADD, OP_ADC: begin
            r = sum[31:0] & wm; dres_d = r; dw_d = 1'b1;
            flags_d = {((~(d ^ s)) & (d ^ r) & wsb) != 0, (r & wsb) != 0, r == 0,
                       sum > {1'b0, wm}};
          end
          OP_SUB, OP_CMP, OP_SBB: begin
            r = (d - sub_v[31:0]) & wm;
            flags_d = {((d ^ s) & (d ^ r) & wsb) != 0, (r & wsb) != 0, r == 0,
                       {1'b0, d} < sub_v};
            if (s_axis_tuser != OP_CMP) begin dres_d = r; dw_d = 1'b1; end
          end
          OP_INC: begin
            r = (d + 32'd1) & wm; dres_d = r; dw_d = 1'b1;
            flags_d = {d == wsb - 32'd1, (r & wsb) != 0, r == 0, c};
          end
          OP_MUL, OP_IMUL1, OP_IMUL2, OP_IMUL3: begin
            // the one-operand signed form works on magnitudes and fixes the sign at the end
            a_d = (s_axis_tuser == OP_IMUL3) ? s2 : d;
            b_d = (s_axis_tuser == OP_MUL || s_axis_tuser == OP_IMUL1) ? (alo & wm) : s;
            if (s_axis_tuser == OP_IMUL1) begin
              nn_d = (a_d & wsb) != 0; nd_d = (b_d & wsb) != 0;
              if (nn_d) a_d = (32'd0 - a_d) & wm;
              if (nd_d) b_d = (32'd0 - b_d) & wm;
            end
            st_d = ST_MUL;
          end
          OP_DIV, OP_IDIV: begin
            if (d == 0) err_d = 1'b1;
            else begin
              acc_d = dvd; a_d = d;
              if (s_axis_tuser == OP_IDIV) begin
                nn_d = (dvd & nsb2) != 0; nd_d = (d & wsb) != 0;
                if (nn_d) acc_d = (64'd0 - dvd) & wm2;
                if (nd_d) a_d = (32'd0 - d) & wm;
              end
              // align the dividend so its top bit enters first
              acc_d = (sz == SZ_BYTE) ? (acc_d << 48) : (sz == SZ_WORD) ? (acc_d << 32)
                    : acc_d;
              st_d = ST_DIV;
            end
          end
          default: ;
        endcase
      end
      ST_MUL: begin
        if (b_q[cnt_q[4:0]]) acc_d = acc_q + ({32'd0, a_q} << cnt_q[4:0]);
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == w_q) st_d = ST_MULFIX;
      end
      ST_MULFIX: begin
        p = (nn_q != nd_q) ? (64'd0 - acc_q) : acc_q;
        if (op_q == OP_IMUL2 || op_q == OP_IMUL3) begin
          dres_d = p[31:0] & m_q; dw_d = 1'b1;
        end else begin
          aw_d = 1'b1;
          if (w_q == 6'd8) begin lo_d = {16'd0, p[15:0]}; hi_d = '0; end
          else if (w_q == 6'd16) begin lo_d = {16'd0, p[15:0]}; hi_d = {16'd0, p[31:16]}; end
          else begin lo_d = p[31:0]; hi_d = p[63:32]; end
        end
        st_d = ST_OUT;
      end
      ST_DIV: begin
        // quotient bits shift into the low end of acc as the dividend leaves
        // partial remainder stays below the divisor, so 32 bits hold it
        if (!trial[32]) begin
          rem_d = trial[31:0]; acc_d = {acc_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], acc_q[63]}; acc_d = {acc_q[62:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == {w_q[4:0], 1'b0}) st_d = ST_DIVFIX;
      end
      ST_DIVFIX: begin
        qx = acc_q & ((w_q == 6'd8) ? 64'hFFFF : (w_q == 6'd16) ? 64'hFFFF_FFFF : '1);
        rx = rem_q;
        if (op_q == OP_DIV) begin
          err_d = qx > {32'd0, m_q};
        end else begin
          err_d = (nn_q != nd_q) ? (qx > {32'd0, sb_q}) : (qx > {32'd0, sb_q - 32'd1});
          if (nn_q != nd_q) qx = 64'd0 - qx;
          if (nn_q) rx = 32'd0 - rx;
        end
        if (!err_d) begin lo_d = qx[31:0] & m_q; hi_d = rx & m_q; aw_d = 1'b1; end
        st_d = ST_OUT;
      end
      ST_OUT: if (m_axis_tready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      flags_q <= '0;
    end else begin
      st_q <= st_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; w_q <= w_d; m_q <= m_d; sb_q <= sb_d; a_q <= a_d; b_q <= b_d;
    acc_q <= acc_d; rem_q <= rem_d; cnt_q <= cnt_d; nn_q <= nn_d; nd_q <= nd_d;
    dres_q <= dres_d; lo_q <= lo_d; hi_q <= hi_d; dw_q <= dw_d; aw_q <= aw_d;
    err_q <= err_d;
  end

  assign m_axis_tvalid = (st_q == ST_OUT);
  assign m_axis_tdata = {1'b0, err_q, flags_q[3], flags_q[2], flags_q[1], flags_q[0],
                         aw_q, hi_q, lo_q, dw_q, dres_q};

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
  a_err_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err_q |-> !aw_q && !dw_q) else $error("write on divide error");
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE |=> $stable(flags_q)) else $error("flags moved while busy");
endmodule
`default_nettype wire

// File: bench/tb_x86_integer_alu_with_flags.sv
// testbench for the x86 integer alu: directed and random operations checked
// against a behavioral predictor of results and flags; depends on xalu_pkg
`default_nettype none
module tb_x86_integer_alu_with_flags;
  import xalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 20000;

  // laid out to match the result beat, highest bit first
  typedef struct packed {
    logic        err, of, sf, zf, cf;
    logic        aw;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        dw;
    logic [31:0] dres;
  } alu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  alu_res_t expected_q[$];
  logic [3:0] pred_flags;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit fail_seen = 1'b0;

  x86_integer_alu_with_flags i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sext(logic [63:0] v, int unsigned w);
    logic [63:0] x;
    x = v << (64 - w);
    return $signed(x) >>> (64 - w);
  endfunction

  // computes one result and advances the predicted flags
  function automatic alu_res_t alu_predict(logic [3:0] op, logic [1:0] sz,
      logic [31:0] dv, logic [31:0] sv, logic [31:0] s2v, logic [31:0] al, logic [31:0] ah);
    alu_res_t res;
    int unsigned w;
    logic [63:0] m, sb, d, s, s2, c, r, sub, p, dvd, mn, md, q, rem, nsb, nm;
    bit nn, nd, upd, ncf, nof;
    res = '0;
    w = (sz == 2'd0) ? 8 : (sz == 2'd1) ? 16 : 32;
    m = (64'd1 << w) - 1;
    sb = 64'd1 << (w - 1);
    d = dv & m; s = sv & m; s2 = s2v & m;
    c = {63'd0, pred_flags[0]};
    upd = 1'b0; ncf = 1'b0; nof = 1'b0; r = '0;
    case (op)
      OP_ADD, OP_ADC: begin
        r = d + s + ((op == OP_ADC) ? c : 64'd0);
        res.dres = r[31:0] & m[31:0]; res.dw = 1'b1; upd = 1'b1;
        ncf = r > m; nof = ((~(d ^ s)) & (d ^ {32'd0, res.dres}) & sb) != 0;
      end
      OP_SUB, OP_CMP, OP_SBB: begin
        sub = s + ((op == OP_SBB) ? c : 64'd0);
        r = (d - sub) & m; upd = 1'b1;
        ncf = d < sub; nof = ((d ^ s) & (d ^ r) & sb) != 0;
        if (op != OP_CMP) begin
          res.dres = r[31:0]; res.dw = 1'b1;
        end
      end
      OP_INC: begin
        res.dres = 32'((d + 1) & m); res.dw = 1'b1; upd = 1'b1;
        ncf = c[0]; nof = d == sb - 1;
      end
      OP_MUL, OP_IMUL1: begin
        if (op == OP_MUL) p = d * (al & m);
        else p = sext(d, w) * sext(al, w);
        res.aw = 1'b1;
        if (w == 8) res.lo = 32'(p & 64'hFFFF);
        else begin
          res.lo = 32'(p & m); res.hi = 32'((p >> w) & m);
        end
      end
      OP_IMUL2, OP_IMUL3: begin
        res.dres = 32'((((op == OP_IMUL2) ? d : s2) * s) & m); res.dw = 1'b1;
      end
      OP_DIV, OP_IDIV: begin
        nn = 1'b0; nd = 1'b0;
        if (w == 8) dvd = al & 64'hFFFF;
        else if (w == 16) dvd = ((ah & 64'hFFFF) << 16) | (al & 64'hFFFF);
        else dvd = {ah, al};
        if (d == 0) res.err = 1'b1;
        else begin
          mn = dvd; md = d;
          if (op == OP_IDIV) begin
            nsb = 64'd1 << (2 * w - 1);
            nm = (w == 32) ? '1 : ((nsb << 1) - 1);
            if (dvd & nsb) begin
              nn = 1'b1; mn = (0 - dvd) & nm;
            end
            if (d & sb) begin
              nd = 1'b1; md = (0 - d) & m;
            end
          end
          q = mn / md; rem = mn % md;
          if (op == OP_DIV) res.err = q > m;
          else begin
            res.err = (nn != nd) ? (q > sb) : (q > sb - 1);
            if (nn != nd) q = 0 - q;
            if (nn) rem = 0 - rem;
          end
          if (!res.err) begin
            res.lo = 32'(q & m); res.hi = 32'(rem & m); res.aw = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (upd) pred_flags = {nof, (r & sb) != 0, (r & m) == 0, ncf};
    if (op == OP_ADD || op == OP_ADC || op == OP_INC) begin
      r = {32'd0, res.dres};
      pred_flags[1] = r == 0;
      pred_flags[2] = (r & sb) != 0;
    end
    {res.of, res.sf, res.zf, res.cf} = pred_flags;
    return res;
  endfunction

  task automatic random_gap(int unsigned base);
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, base);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_op(logic [3:0] op, logic [1:0] sz, logic [31:0] dv, logic [31:0] sv,
      logic [31:0] s2v, logic [31:0] al, logic [31:0] ah, bit gaps = 1'b1);
    if (gaps && $urandom_range(0, 2) == 0) random_gap(2);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, ah, al, s2v, sv, dv, sz};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(alu_predict(op, sz, dv, sv, s2v, al, ah));
    s_axis_tvalid <= 1'b0;
    // the block is busy in the cycle after a beat, so this costs no rate
    @(posedge clk_i);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    alu_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[102:0];
      if (expected_q.size() == 0) begin
        fail_seen <= 1'b1;
        if (mismatches < 10) $display("unexpected result %h", got);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_seen <= 1'b1;
          if (mismatches < 10)
            $display("mismatch: expected %h actual %h", want, got);
          mismatches <= mismatches + 1;
        end
      end
    end
    if (rst_ni) begin
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold <= rx_hold - 1;
      end else if ($urandom_range(0, 49) == 0) begin
        // occasional long receiver stall
        m_axis_tready <= 1'b0;
        rx_hold <= $urandom_range(5, 40);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return {24'd0, 8'($urandom_range(0, 255))};
      3: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic [1:0] sz;
    for (int k = 0; k < 3; k++) begin
      sz = 2'(k);
      send_op(OP_ADD, sz, 32'hFFFF_FFFF, 32'd1, '0, '0, '0);
      send_op(OP_ADC, sz, 32'h7FFF_FF7F, 32'd0, '0, '0, '0);
      send_op(OP_SBB, sz, 32'd0, 32'hFFFF_FFFF, '0, '0, '0);
      send_op(OP_INC, sz, 32'h7FFF_7F7F, '0, '0, '0, '0);
      send_op(OP_MUL, sz, 32'hFFFF_FFFF, '0, '0, 32'hFFFF_FFFF, '0);
      send_op(OP_IDIV, sz, 32'hFFFF_FFFF, '0, '0, 32'h8000_8080, 32'hFFFF_FFFF);
      send_op(OP_DIV, sz, 32'd0, '0, '0, 32'd1234, 32'd0);
    end
    send_op(OP_SUB, 2'd2, 32'h8000_0000, 32'd1, '0, '0, '0);
    send_op(OP_CMP, 2'd0, 32'h55, 32'h55, '0, '0, '0);
    send_op(OP_IMUL1, 2'd1, 32'h8000, '0, '0, 32'h8000, '0);
    send_op(OP_IMUL2, 2'd0, 32'hFF, 32'h81, '0, '0, '0);
    send_op(OP_IMUL3, 2'd3, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0);
    send_op(4'd14, 2'd0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random(int unsigned n);
    logic [3:0] op;
    logic [1:0] sz;
    logic [31:0] dv, al, ah;
    for (int unsigned i = 0; i < n; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      sz = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 1));
      dv = rand_val(); al = rand_val(); ah = rand_val();
      // mostly divides whose quotient fits
      if ((op == OP_DIV || op == OP_IDIV) && $urandom_range(0, 3) != 0) begin
        // keep the divisor nonzero at every size
        if ((dv & 32'hFF) == 0) dv = dv | 32'd3;
        ah = (sz == 2'd1) ? ah % (dv & 32'hFFFF) : ah % dv;
        if (op == OP_IDIV) ah = 32'd0;
        if (op == OP_IDIV) al = al >> 2;
      end
      send_op(op, sz, dv, rand_val(), rand_val(), al, ah);
      if (i % 50 == 25) random_gap(0);
    end
  endtask

  task automatic test_drain_pause();
    send_op(OP_ADD, 2'd2, $urandom(), $urandom(), '0, '0, '0, 1'b0);
    while (expected_q.size() != 0) @(posedge clk_i);
    send_op(OP_ADC, 2'd1, $urandom(), $urandom(), '0, '0, '0, 1'b0);
    send_op(OP_DIV, 2'd2, 32'd7, '0, '0, $urandom(), 32'd1, 1'b0);
  endtask

  initial begin
    pred_flags = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(400);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (!fail_seen && mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
